### hw/rtl/hamming_encode_check_top_defines.svh
// assertion macros for the hamming encode and check block
`ifndef HAMMING_ENCODE_CHECK_TOP_DEFINES_SVH
`define HAMMING_ENCODE_CHECK_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define HEC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HEC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define HEC_ASSERT(label, prop, msg)
`define HEC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### hw/rtl/hec_pkg.sv
// shared types, constants and code-geometry functions for the hamming codec
package hec_pkg;

    localparam int WORD_W            = 64;
    localparam int DATA_BITS_W       = 6;
    localparam int SYN_W             = 6;
    localparam int CHECK_MAX         = 7;
    localparam int DATA_BITS_RESET   = 4;
    localparam int MAX_WORD_BITS_DEF = 64;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_command;

    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // smallest r with 2^r >= d + r + 1
    function automatic int check_count(input int d);
        int r;
        r = 0;
        for (int k = 0; k < 8; k++) begin
            if ((1 << r) < (d + r + 1)) begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // largest data length whose code word fits in maxw bits
    function automatic int max_data_bits(input int maxw);
        int best;
        best = 0;
        for (int d = 0; d < 64; d++) begin
            if ((d + check_count(d)) <= maxw) begin
                best = d;
            end
        end
        return best;
    endfunction

    // 0-based code index of the x-th non power of two position
    function automatic int data_pos(input int x);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int j = 0; j < 128; j++) begin
            if (!is_pow2(j + 1)) begin
                if (cnt == x) begin
                    pos = j;
                end
                cnt = cnt + 1;
            end
        end
        return pos;
    endfunction

endpackage

### hw/rtl/hamming_encode_check_top.sv
// hamming encoder and single-error syndrome checker, one word per cycle while the output is not stalled
//
//  channel  valid        ready        payload
//  in       i_in_valid   o_in_ready   i_command, i_word_in
//  out      o_out_valid  i_out_ready  o_word_out, o_syndrome, o_error_found,
//                                     o_error_position, o_syndrome_invalid
//  cfg      i_cfg_valid  o_cfg_ready  i_cfg_data
//
// data passes an input register, then the parity and bit placement network into the
// result register. one transaction is taken per cycle while o_in_ready is high.
// a stalled output holds the result register and the input register, and ready
// drops only when both are full.
// synchronous active-low reset empties both stages and sets data_bits to 4.
`include "hamming_encode_check_top_defines.svh"

module hamming_encode_check_top
    import hec_pkg::*;
#(
    parameter int P_MAX_WORD_BITS = MAX_WORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_command,
    input  logic [WORD_W-1:0]      i_word_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [WORD_W-1:0]      o_word_out,
    output logic [SYN_W-1:0]       o_syndrome,
    output logic                   o_error_found,
    output logic [SYN_W-1:0]       o_error_position,
    output logic                   o_syndrome_invalid,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [DATA_BITS_W-1:0] i_cfg_data
);

    localparam int L_P     = P_MAX_WORD_BITS;
    localparam int L_NW    = $clog2(L_P + 1);
    localparam int L_DMAX  = max_data_bits(L_P);
    localparam int L_D_RST = (DATA_BITS_RESET > L_DMAX) ? L_DMAX : DATA_BITS_RESET;
    localparam int L_N_RST = L_D_RST + check_count(L_D_RST);

    // configuration: saturated data length and code length
    logic [DATA_BITS_W-1:0] r_d;
    logic [L_NW-1:0]        r_n;
    logic [DATA_BITS_W-1:0] n_d;
    logic [L_NW-1:0]        n_n;

    // pipeline registers
    logic                   r_s1_valid;
    logic                   r_cmd;
    logic [L_P-1:0]         r_word;
    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_word_out;
    logic [SYN_W-1:0]       r_syndrome;
    logic                   r_error_found;
    logic [SYN_W-1:0]       r_error_position;
    logic                   r_syndrome_invalid;

    logic                   s1_adv;
    logic                   in_take;

    // datapath
    t_command               cmd;
    logic [L_P-1:0]         rev_in;
    logic [L_P-1:0]         dvec;
    logic [L_P-1:0]         dec_code;
    logic [L_P-1:0]         enc_pre;
    logic [L_P-1:0]         code;
    logic [L_P-1:0]         enc_code;
    logic [L_P-1:0]         rev_enc;
    logic [L_P-1:0]         ext;
    logic [L_P-1:0]         rev_ext;
    logic [CHECK_MAX-1:0]   par;
    logic [L_NW-1:0]        sh_n;
    logic [L_NW-1:0]        sh_d;
    logic [L_NW-1:0]        pos_full;
    logic [L_P-1:0]         enc_word;
    logic [L_P-1:0]         dec_word;

    logic [WORD_W-1:0]      n_word_out;
    logic [SYN_W-1:0]       n_syndrome;
    logic                   n_error_found;
    logic [SYN_W-1:0]       n_error_position;
    logic                   n_syndrome_invalid;

    assign o_cfg_ready = 1'b1;
    assign s1_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_take     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_cfg_data > DATA_BITS_W'(L_DMAX)) begin
            n_d = DATA_BITS_W'(L_DMAX);
        end else begin
            n_d = i_cfg_data;
        end
        n_n = L_NW'(int'(n_d) + check_count(int'(n_d)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= DATA_BITS_W'(L_D_RST);
            r_n <= L_NW'(L_N_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_d <= n_d;
            r_n <= n_n;
        end
    end

    always_comb begin
        cmd  = t_command'(r_cmd);
        sh_n = L_NW'(L_P) - r_n;
        sh_d = L_NW'(L_P) - L_NW'(r_d);

        for (int j = 0; j < L_P; j++) begin
            rev_in[j] = r_word[L_P-1-j];
        end
        // data elements reversed, code elements reversed, upper bits cleared by the shift
        dvec     = rev_in >> sh_d;
        dec_code = rev_in >> sh_n;

        enc_pre = '0;
        for (int x = 0; x < L_DMAX; x++) begin
            enc_pre[data_pos(x)] = dvec[x];
        end

        code = (cmd == CMD_DECODE) ? dec_code : enc_pre;

        // positions past n are zero, so the fixed masks cover any length
        par = '0;
        for (int i = 0; i < CHECK_MAX; i++) begin
            for (int j = 0; j < L_P; j++) begin
                if ((((j + 1) >> i) & 1) != 0) begin
                    par[i] = par[i] ^ code[j];
                end
            end
        end

        enc_code = enc_pre;
        for (int i = 0; i < CHECK_MAX; i++) begin
            if (((1 << i) - 1) < L_P) begin
                enc_code[(1 << i) - 1] = par[i];
            end
        end

        ext = '0;
        for (int x = 0; x < L_DMAX; x++) begin
            ext[x] = code[data_pos(x)];
        end

        for (int j = 0; j < L_P; j++) begin
            rev_enc[j] = enc_code[L_P-1-j];
            rev_ext[j] = ext[L_P-1-j];
        end
        enc_word = rev_enc >> sh_n;
        dec_word = rev_ext >> sh_d;

        pos_full = r_n - L_NW'(par) + L_NW'(1);

        n_word_out         = '0;
        n_syndrome         = '0;
        n_error_found      = 1'b0;
        n_error_position   = '0;
        n_syndrome_invalid = 1'b0;
        if (cmd == CMD_DECODE) begin
            n_word_out[L_P-1:0] = dec_word;
            n_syndrome          = par[SYN_W-1:0];
            n_error_found       = (par != '0);
            if (par != '0) begin
                if (L_NW'(par) > r_n) begin
                    n_syndrome_invalid = 1'b1;
                end else begin
                    n_error_position = pos_full[SYN_W-1:0];
                end
            end
        end else begin
            n_word_out[L_P-1:0] = enc_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= i_command;
            r_word <= i_word_in[L_P-1:0];
        end
        if (s1_adv && r_s1_valid) begin
            r_word_out         <= n_word_out;
            r_syndrome         <= n_syndrome;
            r_error_found      <= n_error_found;
            r_error_position   <= n_error_position;
            r_syndrome_invalid <= n_syndrome_invalid;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_word_out         = r_word_out;
    assign o_syndrome         = r_syndrome;
    assign o_error_found      = r_error_found;
    assign o_error_position   = r_error_position;
    assign o_syndrome_invalid = r_syndrome_invalid;

    // a held input transaction is not overwritten while the output stalls
    `HEC_ASSERT(a_s1_hold, r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_word) && $stable(r_cmd), "input stage lost a held transaction")
    // a flagged syndrome never carries a position
    `HEC_ASSERT(a_invalid_flags, o_out_valid && o_syndrome_invalid |-> o_error_found && (o_error_position == '0), "invalid syndrome with position")
    // no error means no syndrome and no position
    `HEC_ASSERT(a_clean_result, o_out_valid && !o_error_found |-> (o_syndrome == '0) && (o_error_position == '0) && !o_syndrome_invalid, "error fields set without error")
    // both stages are empty right after reset
    `HEC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !r_s1_valid, "pipeline not empty after reset")

endmodule
